// ----- src/hec_pkg.sv -----
// Shared constants, types and the colour ramp for the equalized colormap.
package hec_pkg;

    localparam int MAX_POINTS  = 4096;
    localparam int BIN_COUNT   = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int PT_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS  = PT_BITS + 1;
    localparam int BIN_BITS  = $clog2(BIN_COUNT);
    localparam int NUM_BITS  = SAMPLE_BITS + BIN_BITS;
    localparam int STEP_BITS = $clog2(BIN_BITS);

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_DROPPED   = 2'd2;

    // Request into the shared divider
    typedef struct packed {
        logic                   start;
        logic [NUM_BITS-1:0]    num;
        logic [SAMPLE_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Blue-white-red ramp over the equalized index
    function automatic t_rgb colour_of(input logic [BIN_BITS-1:0] j);
        t_rgb c;
        int   v;
        if (int'(j) < BIN_COUNT / 2) begin
            v       = (510 * int'(j)) / BIN_COUNT;
            c.red   = v[7:0];
            c.green = v[7:0];
            c.blue  = 8'd255;
        end else begin
            v = (510 * (BIN_COUNT - int'(j))) / BIN_COUNT;
            if (v > 255) begin
                v = 255;
            end
            c.red   = 8'd255;
            c.green = v[7:0];
            c.blue  = v[7:0];
        end
        return c;
    endfunction

endpackage

// ----- src/hec_div.sv -----
// Restoring divider, one quotient bit per cycle; zero divisor gives zero.
module hec_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  hec_pkg::t_div_req         i_req,
    output logic                      o_done,
    output logic [hec_pkg::BIN_BITS-1:0] o_quot
);
    import hec_pkg::*;

    logic                   r_run;
    logic [STEP_BITS-1:0]   r_step;
    logic [NUM_BITS-1:0]    r_rem;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [BIN_BITS-1:0]    r_q;
    logic                   r_done;
    logic [NUM_BITS-1:0]    trial;

    // Divisor aligned to the current quotient bit
    assign trial = {{BIN_BITS{1'b0}}, r_den} << r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run  <= 1'b1;
                r_step <= STEP_BITS'(BIN_BITS - 1);
                r_rem  <= i_req.num;
                r_den  <= i_req.den;
                r_q    <= '0;
            end else if (r_run) begin
                if (r_rem >= trial) begin
                    r_rem         <= r_rem - trial;
                    r_q[r_step]   <= 1'b1;
                end
                if (r_step == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_den == '0) ? '0 : r_q;

endmodule

// ----- src/histogram_equalized_colormap.sv -----
// Top level: point store, binning and equalization passes, colour lookup.
// A load is taken while idle; a read passes S_RD_MAP and S_RD_OUT to a
// registered result (in the next cycle when rejected). The compute pass after
// the last sample holds busy while each loaded point is binned and each bin
// mapped by the shared one-bit-per-cycle divider. Results cannot be stalled.
// Reset is synchronous; afterwards a pass over every bin clears the bin counts.
module histogram_equalized_colormap (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic [hec_pkg::SAMPLE_BITS-1:0] i_intensity,
    input  logic                          i_last_sample,
    input  logic [hec_pkg::PT_BITS-1:0]   i_point_index,
    output logic                          o_valid,
    output logic [7:0]                    o_red,
    output logic [7:0]                    o_green,
    output logic [7:0]                    o_blue,
    output logic [1:0]                    o_status
);
    import hec_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE,
        S_BIN_RD, S_BIN_START, S_BIN_DIV, S_BIN_CNT,
        S_MAP_RD, S_MAP_START, S_MAP_DIV,
        S_RD_MAP, S_RD_OUT
    } t_state;

    t_state                 r_state;
    logic [CNT_BITS-1:0]    r_idx;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    r_cum;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [BIN_BITS-1:0]    r_bin;
    logic                   r_ovf;
    logic                   r_set_ready;

    // Memories and their registered read data
    logic [SAMPLE_BITS-1:0] sample_store [MAX_POINTS];
    logic [BIN_BITS-1:0]    bin_store    [MAX_POINTS];
    logic [CNT_BITS-1:0]    bin_counts   [BIN_COUNT];
    logic [BIN_BITS-1:0]    bin_remap    [BIN_COUNT];
    logic [SAMPLE_BITS-1:0] r_smp_q;
    logic [BIN_BITS-1:0]    r_binst_q;
    logic [CNT_BITS-1:0]    r_cnt_q;
    logic [BIN_BITS-1:0]    r_map_q;

    logic                   accept;
    logic [CNT_BITS-1:0]    eff_cnt;
    logic [SAMPLE_BITS-1:0] eff_lo;
    logic [SAMPLE_BITS-1:0] eff_hi;
    logic                   eff_ovf;
    logic                   has_room;
    logic                   rd_bad;
    logic [CNT_BITS-1:0]    n_idx;
    logic [CNT_BITS-1:0]    n_cum;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   smp_we;
    logic                   cnt_we;
    logic [BIN_BITS-1:0]    cnt_waddr;
    logic [CNT_BITS-1:0]    cnt_wdata;
    logic [BIN_BITS-1:0]    cnt_raddr;
    t_div_req               div_req;
    logic                   div_done;
    logic [BIN_BITS-1:0]    div_q;
    t_rgb                   rgb;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // A load after a finished set starts a fresh one
    assign eff_cnt  = r_set_ready ? '0 : r_count;
    assign eff_lo   = r_set_ready ? '1 : r_lo;
    assign eff_hi   = r_set_ready ? '0 : r_hi;
    assign eff_ovf  = r_set_ready ? 1'b0 : r_ovf;
    assign has_room = (eff_cnt < CNT_BITS'(MAX_POINTS));
    assign rd_bad   = !r_set_ready || ({1'b0, i_point_index} >= r_count);
    assign n_idx    = r_idx + 1'b1;
    assign n_cum    = r_cum + r_cnt_q;
    assign diff     = r_smp_q - r_lo;
    assign smp_we   = accept && !i_mode && has_room;

    // Divider operands: bin scaling, then equalization mapping
    always_comb begin
        div_req.start = (r_state == S_BIN_START) || (r_state == S_MAP_START);
        if (r_state == S_MAP_START) begin
            div_req.num = NUM_BITS'({n_cum, {BIN_BITS{1'b0}}} - {{BIN_BITS{1'b0}}, n_cum});
            div_req.den = SAMPLE_BITS'(r_count);
        end else begin
            div_req.num = {diff, {BIN_BITS{1'b0}}} - {{BIN_BITS{1'b0}}, diff};
            div_req.den = r_hi - r_lo;
        end
    end

    hec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Bin count write port: clear sweep, increment, clear after use
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = r_idx[BIN_BITS-1:0];
        cnt_wdata = '0;
        case (r_state)
            S_CLEAR:     cnt_we = 1'b1;
            S_MAP_START: cnt_we = 1'b1;
            S_BIN_CNT: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_bin;
                cnt_wdata = r_cnt_q + 1'b1;
            end
            default: cnt_we = 1'b0;
        endcase
        cnt_raddr = (r_state == S_BIN_DIV) ? div_q : r_idx[BIN_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (smp_we) begin
            sample_store[eff_cnt[PT_BITS-1:0]] <= i_intensity;
        end
        r_smp_q <= sample_store[r_idx[PT_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_BIN_DIV && div_done) begin
            bin_store[r_idx[PT_BITS-1:0]] <= div_q;
        end
        r_binst_q <= bin_store[i_point_index];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            bin_counts[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_q <= bin_counts[cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MAP_DIV && div_done) begin
            bin_remap[r_idx[BIN_BITS-1:0]] <= div_q;
        end
        r_map_q <= bin_remap[r_binst_q];
    end

    assign rgb = colour_of(r_map_q);

    // Sequencer and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_lo        <= '1;
            r_hi        <= '0;
            r_ovf       <= 1'b0;
            r_set_ready <= 1'b0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_idx <= n_idx;
                    if (r_idx[BIN_BITS-1:0] == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && !i_mode) begin
                        r_set_ready <= 1'b0;
                        if (has_room) begin
                            r_count <= eff_cnt + 1'b1;
                            r_lo    <= (i_intensity < eff_lo) ? i_intensity : eff_lo;
                            r_hi    <= (i_intensity > eff_hi) ? i_intensity : eff_hi;
                            r_ovf   <= eff_ovf;
                        end else begin
                            r_count <= eff_cnt;
                            r_lo    <= eff_lo;
                            r_hi    <= eff_hi;
                            r_ovf   <= 1'b1;
                        end
                        if (i_last_sample) begin
                            r_idx   <= '0;
                            r_state <= S_BIN_RD;
                        end
                    end else if (accept) begin
                        if (rd_bad) begin
                            o_valid  <= 1'b1;
                            o_red    <= '0;
                            o_green  <= '0;
                            o_blue   <= '0;
                            o_status <= ST_NOT_READY;
                        end else begin
                            r_state <= S_RD_MAP;
                        end
                    end
                end
                S_BIN_RD:    r_state <= S_BIN_START;
                S_BIN_START: r_state <= S_BIN_DIV;
                S_BIN_DIV: begin
                    if (div_done) begin
                        r_bin   <= div_q;
                        r_state <= S_BIN_CNT;
                    end
                end
                S_BIN_CNT: begin
                    if (n_idx == r_count) begin
                        r_idx   <= '0;
                        r_cum   <= '0;
                        r_state <= S_MAP_RD;
                    end else begin
                        r_idx   <= n_idx;
                        r_state <= S_BIN_RD;
                    end
                end
                S_MAP_RD: r_state <= S_MAP_START;
                S_MAP_START: begin
                    r_cum   <= n_cum;
                    r_state <= S_MAP_DIV;
                end
                S_MAP_DIV: begin
                    if (div_done) begin
                        if (r_idx[BIN_BITS-1:0] == '1) begin
                            r_set_ready <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx   <= n_idx;
                            r_state <= S_MAP_RD;
                        end
                    end
                end
                S_RD_MAP: r_state <= S_RD_OUT;
                S_RD_OUT: begin
                    o_valid  <= 1'b1;
                    o_red    <= rgb.red;
                    o_green  <= rgb.green;
                    o_blue   <= rgb.blue;
                    o_status <= r_ovf ? ST_DROPPED : ST_OK;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A good colour only comes from a finished set
    a_ok_needs_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_NOT_READY) |-> r_set_ready)
        else $error("colour returned without a finished set");

    // Divider completions only while a pass waits for them
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_BIN_DIV || r_state == S_MAP_DIV))
        else $error("unexpected divider completion");

    // Before its increment a bin holds fewer entries than the whole set
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BIN_CNT) |-> (r_cnt_q < r_count))
        else $error("bin count exceeds loaded points");

    // Range stays ordered once any sample is held
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (r_lo <= r_hi))
        else $error("minimum above maximum");

endmodule

// ----- verif/histogram_equalized_colormap_test.sv -----
// Testbench for the histogram-equalized colormap: directed and random load/read traffic.
module histogram_equalized_colormap_test;
    import hec_pkg::*;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } t_colour_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic                   i_mode;
    logic [SAMPLE_BITS-1:0] i_intensity;
    logic                   i_last_sample;
    logic [PT_BITS-1:0]     i_point_index;
    logic                   o_valid;
    logic [7:0]             o_red;
    logic [7:0]             o_green;
    logic [7:0]             o_blue;
    logic [1:0]             o_status;

    histogram_equalized_colormap i_dut (.*);

    // Shadow copy of the block state
    logic [SAMPLE_BITS-1:0] shadow_samples [MAX_POINTS];
    logic [BIN_BITS-1:0]    shadow_bins    [MAX_POINTS];
    logic [BIN_BITS-1:0]    shadow_remap   [BIN_COUNT];
    longint                 hist           [BIN_COUNT];
    logic [SAMPLE_BITS-1:0] lowest;
    logic [SAMPLE_BITS-1:0] highest;
    int                     n_loaded;
    bit                     dropped;
    bit                     set_done;

    t_colour_result pending_colours[$];
    int errors;
    int n_loads, n_reads, n_sets, n_checked, n_dropped_reads;
    int items;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Timeout at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic clear_set();
        lowest   = '1;
        highest  = '0;
        n_loaded = 0;
        dropped  = 1'b0;
        set_done = 1'b0;
    endtask

    // Bin the set, build the histogram and the equalized remap
    task automatic equalize_set();
        longint span, b, cum, m;
        span = longint'(highest) - longint'(lowest);
        cum  = 0;
        for (int k = 0; k < BIN_COUNT; k++) hist[k] = 0;
        for (int k = 0; k < n_loaded; k++) begin
            b = 0;
            if (highest > lowest)
                b = (longint'(shadow_samples[k]) - longint'(lowest)) * (BIN_COUNT - 1) / span;
            if (b > BIN_COUNT - 1) b = BIN_COUNT - 1;
            shadow_bins[k] = b[BIN_BITS-1:0];
            hist[b]++;
        end
        for (int k = 0; k < BIN_COUNT; k++) begin
            cum += hist[k];
            m = (n_loaded != 0) ? (BIN_COUNT - 1) * cum / n_loaded : 0;
            if (m > BIN_COUNT - 1) m = BIN_COUNT - 1;
            shadow_remap[k] = m[BIN_BITS-1:0];
        end
        set_done = 1'b1;
        n_sets++;
    endtask

    task automatic predict_load(input logic [SAMPLE_BITS-1:0] v, input logic last);
        if (set_done) clear_set();
        if (n_loaded < MAX_POINTS) begin
            shadow_samples[n_loaded] = v;
            n_loaded++;
            if (v < lowest)  lowest  = v;
            if (v > highest) highest = v;
        end else begin
            dropped = 1'b1;
        end
        if (last) equalize_set();
    endtask

    task automatic predict_read(input logic [PT_BITS-1:0] idx);
        t_colour_result c;
        int j, v;
        if (!set_done || int'(idx) >= n_loaded) begin
            c = '{8'd0, 8'd0, 8'd0, ST_NOT_READY};
        end else begin
            j = int'(shadow_remap[shadow_bins[idx]]);
            if (j < BIN_COUNT / 2) begin
                v = 510 * j / BIN_COUNT;
                c.red = v[7:0]; c.green = v[7:0]; c.blue = 8'd255;
            end else begin
                v = 510 * (BIN_COUNT - j) / BIN_COUNT;
                if (v > 255) v = 255;
                c.red = 8'd255; c.green = v[7:0]; c.blue = v[7:0];
            end
            c.status = dropped ? ST_DROPPED : ST_OK;
            if (dropped) n_dropped_reads++;
        end
        pending_colours.insert(pending_colours.size(), c);
    endtask

    // Send one transaction after a random gap; returns once accepted
    task automatic send_item(input logic mode, input logic [SAMPLE_BITS-1:0] v,
                             input logic last, input logic [PT_BITS-1:0] idx);
        int  gap;
        bit  taken;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_mode        <= mode;
        i_intensity   <= v;
        i_last_sample <= last;
        i_point_index <= idx;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        if (mode) begin
            predict_read(idx);
            n_reads++;
        end else begin
            predict_load(v, last);
            n_loads++;
        end
        items++;
    endtask

    task automatic load(input logic [SAMPLE_BITS-1:0] v, input logic last);
        send_item(1'b0, v, last, PT_BITS'($urandom));
    endtask

    task automatic read(input logic [PT_BITS-1:0] idx);
        send_item(1'b1, SAMPLE_BITS'($urandom), 1'($urandom), idx);
    endtask

    // Compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_colour_result e;
        if (i_rst_n && o_valid) begin
            if (pending_colours.size() == 0) begin
                $display("%0t: unexpected result r=%0d g=%0d b=%0d st=%0d",
                         $time, o_red, o_green, o_blue, o_status);
                errors++;
            end else begin
                e = pending_colours.pop_front();
                n_checked++;
                if (o_red !== e.red || o_green !== e.green || o_blue !== e.blue
                    || o_status !== e.status) begin
                    $display("%0t: mismatch exp r=%0d g=%0d b=%0d st=%0d got r=%0d g=%0d b=%0d st=%0d",
                             $time, e.red, e.green, e.blue, e.status,
                             o_red, o_green, o_blue, o_status);
                    errors++;
                end
            end
        end
    end

    task automatic test_reads_before_set();
        read('0);
        read('1);
    endtask

    // Single sample, flat set, extremes of the intensity range
    task automatic test_edge_sets();
        load(16'h1234, 1'b1);
        read(0);
        read(1);
        load(16'd7, 1'b0);
        load(16'd7, 1'b0);
        load(16'd7, 1'b1);
        read(2);
        read(3);
        load(16'h0000, 1'b0);
        read(0);                  // set still open
        load(16'hFFFF, 1'b0);
        load(16'h8000, 1'b0);
        load(16'h7FFF, 1'b0);
        load(16'h5555, 1'b0);
        load(16'hAAAA, 1'b1);
        for (int k = 0; k < 7; k++) read(k[PT_BITS-1:0]);
    endtask

    task automatic test_random_sets();
        int n, lo_v, span_v, kind;
        logic [SAMPLE_BITS-1:0] v;
        while (items < 1250) begin
            n      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
            kind   = $urandom_range(0, 3);
            lo_v   = $urandom_range(0, 65535);
            span_v = (kind == 0) ? 0 : (kind == 1) ? $urandom_range(1, 300) : 65535;
            for (int k = 0; k < n; k++) begin
                if (kind == 3) v = SAMPLE_BITS'($urandom);
                else v = SAMPLE_BITS'(lo_v + $urandom_range(0, span_v));
                if ($urandom_range(0, 15) == 0) read(PT_BITS'($urandom));
                load(v, k == n - 1);
            end
            repeat ($urandom_range(4, 25)) begin
                if ($urandom_range(0, 7) == 0) read(PT_BITS'($urandom));
                else read(PT_BITS'($urandom_range(0, n)));
            end
        end
    endtask

    // Fill the store, then drop two loads; the dropped last closes the set
    task automatic test_store_full();
        for (int k = 0; k < MAX_POINTS; k++) load(SAMPLE_BITS'($urandom), 1'b0);
        load(16'hFFFF, 1'b0);
        load(16'h0000, 1'b1);
        read('1);
        read('0);
        repeat (20) read(PT_BITS'($urandom));
        // a fresh set after the overflow clears the dropped flag
        load(16'd100, 1'b0);
        load(16'd200, 1'b1);
        read(0);
        read(1);
    endtask

    initial begin
        int waited;
        errors = 0; items = 0; n_loads = 0; n_reads = 0; n_sets = 0;
        n_checked = 0; n_dropped_reads = 0;
        start = 1'b0; i_mode = 1'b0; i_intensity = '0; i_last_sample = 1'b0;
        i_point_index = '0;
        clear_set();
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reads_before_set();
        test_edge_sets();
        test_random_sets();
        test_store_full();
        start <= 1'b0;

        waited = 0;
        while (pending_colours.size() != 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_colours.size() != 0) begin
            $display("%0d results never arrived", pending_colours.size());
            errors++;
        end

        $display("Covered %0d loads in %0d sets and %0d reads; %0d results checked",
                 n_loads, n_sets, n_reads, n_checked);
        $display("Reads with dropped samples: %0d, errors: %0d", n_dropped_reads, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/hec_pkg.sv
src/hec_div.sv
src/histogram_equalized_colormap.sv
verif/histogram_equalized_colormap_test.sv
